// ===== hdl/srg_pkg.sv =====
package srg_pkg;

  localparam int unsigned MAX_PRESCALE_DEF = 7;
  localparam int unsigned PERIOD_BITS_DEF  = 16;
  localparam int unsigned US_PER_S         = 1000000;

  localparam int unsigned FREQ_W = 36;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned DIV_W  = 64;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 36;

  // Register reset values.
  localparam logic [31:0] CLOCK_HZ_RST    = 32'd50000000;
  localparam logic [35:0] START_FREQ_RST  = 36'd196608000;
  localparam logic [35:0] FREQ_STEP_RST   = 36'd6553600;
  localparam logic [15:0] STAGE_COUNT_RST = 16'd1;
  localparam logic [19:0] STAGE_US_RST    = 20'd200;
  localparam logic [31:0] CRUISE_US_RST   = 32'd0;
  localparam logic [31:0] END_TRIM_RST    = 32'd500000;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HZ    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_FREQ  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FREQ_STEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STAGE_US    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_US   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_END_TRIM    = 3'd6;

  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  typedef enum logic [1:0] {
    PH_UP     = 2'd0,
    PH_CRUISE = 2'd1,
    PH_DOWN   = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PER,
    ST_PER_WAIT,
    ST_MUL,
    ST_K_DIV,
    ST_K_WAIT,
    ST_Q_DIV,
    ST_Q_WAIT,
    ST_TRIM,
    ST_TRIM_WAIT,
    ST_EMIT
  } state_t;

endpackage

// ===== hdl/stepper_ramp_stage_generator.sv =====
// Trapezoidal step-rate profile stage generator.
// Input channel (s_*): one beat per command. s_tuser selects the command:
// start loads now_us as the base time and enters ramp-up; advance computes
// one stage. A start gives no result.
// Output channel (m_*): one beat per advance, carrying the PWM prescaler,
// the PWM period and the stage deadline in tdata, the phase in tuser and
// the final ramp-down stage mark in tlast.
// Configuration channel (cfg_*): always ready; write only while idle.
// An advance runs through one shared restoring divider, one quotient
// bit per cycle: the period, the whole-pulse count, the pulse time and,
// on the final stage, the trim; divisions that are not needed (zero
// period, zero frequency, zero divided clock) are skipped. An advance
// after the profile is done goes straight to the result.
// The block takes no new beat while a stage is being worked out.
// The result sits in an output register; the next command is accepted
// while it waits, and the block holds the following result until the
// receiver takes the earlier one.
// Reset restores the register defaults and leaves the profile done.
module stepper_ramp_stage_generator #(
  parameter int unsigned MAX_PRESCALE = srg_pkg::MAX_PRESCALE_DEF,
  parameter int unsigned PERIOD_BITS  = srg_pkg::PERIOD_BITS_DEF,
  localparam int unsigned PRE_W  = $clog2(MAX_PRESCALE + 1),
  localparam int unsigned OUT_W  = PRE_W + PERIOD_BITS + srg_pkg::TIME_W,
  localparam int unsigned OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [31:0]                     s_tdata,  // now_us
  input  logic                            s_tuser,  // func
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [OUT_TW-1:0]               m_tdata,  // prescaler, period, deadline_us
  output logic [1:0]                      m_tuser,  // phase
  output logic                            m_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [srg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [srg_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int unsigned PB = PERIOD_BITS;
  localparam int unsigned DW = srg_pkg::DIV_W;
  localparam logic [PB-1:0] PMAX = '1;

  // Configuration registers.
  logic [31:0] clock_hz;
  logic [35:0] start_freq;
  logic [35:0] freq_step;
  logic [15:0] stage_count;
  logic [19:0] stage_us;
  logic [31:0] cruise_us;
  logic [31:0] end_trim;

  // Profile state.
  logic [35:0]     current_freq;
  logic [15:0]     stage_index;
  logic [31:0]     deadline;
  srg_pkg::phase_t profile_phase;

  srg_pkg::state_t state, state_next;

  // Per-stage working registers.
  logic [35:0]      f_reg;
  logic [PRE_W-1:0] pre_reg;
  logic [31:0]      c_reg;
  logic [PB-1:0]    per_reg;
  srg_pkg::phase_t  ph_cur;
  logic             lst_reg;
  logic [DW-1:0]    dc_reg;
  logic [DW-1:0]    denom_reg;
  logic [31:0]      span_reg;
  logic [31:0]      trim_reg;

  // Shared divider.
  logic          div_start;
  logic [DW-1:0] div_dividend, div_divisor;
  logic [DW-1:0] div_quo, div_rem, div_dsr;
  logic [6:0]    div_cnt;
  logic          div_busy, div_done;
  logic [DW:0]   div_shift, div_diff;
  logic          div_round;
  logic [DW-1:0] div_quo_rnd;

  logic            accept;
  logic            idx_done;
  srg_pkg::phase_t ph_eff;
  logic [PRE_W-1:0] pre_pick;
  logic [31:0]      c_pick;
  logic [48:0]      per_num;
  logic             per_zero;
  logic [PB:0]      per_p1;
  logic [PB+20:0]   denom_prod;
  logic [DW-1:0]    dc_prod;
  logic [31:0]      dur;
  logic [16:0]      idx_p1;
  logic             last_stage;
  logic             out_free;
  logic [36:0]      freq_sum;
  logic [35:0]      freq_up, freq_down;
  logic [31:0]      deadline_new;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz    <= srg_pkg::CLOCK_HZ_RST;
      start_freq  <= srg_pkg::START_FREQ_RST;
      freq_step   <= srg_pkg::FREQ_STEP_RST;
      stage_count <= srg_pkg::STAGE_COUNT_RST;
      stage_us    <= srg_pkg::STAGE_US_RST;
      cruise_us   <= srg_pkg::CRUISE_US_RST;
      end_trim    <= srg_pkg::END_TRIM_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        srg_pkg::REG_CLOCK_HZ:    clock_hz    <= cfg_data[31:0];
        srg_pkg::REG_START_FREQ:  start_freq  <= cfg_data[35:0];
        srg_pkg::REG_FREQ_STEP:   freq_step   <= cfg_data[35:0];
        srg_pkg::REG_STAGE_COUNT: stage_count <= cfg_data[15:0];
        srg_pkg::REG_STAGE_US:    stage_us    <= cfg_data[19:0];
        srg_pkg::REG_CRUISE_US:   cruise_us   <= cfg_data[31:0];
        srg_pkg::REG_END_TRIM:    end_trim    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // A ramp with no stages left is skipped within the same advance.
  assign idx_done = stage_index >= stage_count;
  always_comb begin
    ph_eff = profile_phase;
    if (profile_phase == srg_pkg::PH_UP && idx_done) ph_eff = srg_pkg::PH_CRUISE;
    if (profile_phase == srg_pkg::PH_DOWN && idx_done) ph_eff = srg_pkg::PH_DONE;
  end

  // Smallest prescaler whose divided clock the frequency reaches.
  always_comb begin
    pre_pick = PRE_W'(MAX_PRESCALE);
    for (int p = MAX_PRESCALE - 1; p >= 0; p--) begin
      if ({4'b0, current_freq} >= {8'b0, clock_hz >> p}) pre_pick = PRE_W'(p);
    end
  end
  assign c_pick = clock_hz >> pre_pick;

  assign per_num    = {c_reg, 17'b0};
  assign per_zero   = per_num <= {13'b0, f_reg};
  assign per_p1     = {1'b0, per_reg} + (PB+1)'(1);
  assign denom_prod = (PB+21)'(per_p1) * (PB+21)'(srg_pkg::US_PER_S);
  assign dur        = (ph_cur == srg_pkg::PH_CRUISE) ? cruise_us : {12'b0, stage_us};
  assign dc_prod    = DW'(dur) * DW'(c_reg);
  assign idx_p1     = {1'b0, stage_index} + 17'd1;
  assign last_stage = (ph_cur == srg_pkg::PH_DOWN) && (idx_p1 == {1'b0, stage_count});

  assign freq_sum  = {1'b0, f_reg} + {1'b0, freq_step};
  assign freq_up   = freq_sum[36] ? '1 : freq_sum[35:0];
  assign freq_down = (f_reg < freq_step) ? '0 : f_reg - freq_step;
  assign deadline_new = deadline - trim_reg + span_reg;

  // Restoring divider, one quotient bit a cycle.
  assign div_shift   = {div_rem, div_quo[DW-1]};
  assign div_diff    = div_shift - {1'b0, div_dsr};
  assign div_round   = {div_rem, 1'b0} >= {1'b0, div_dsr};
  assign div_quo_rnd = div_quo + DW'(div_round);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_done <= 1'b0;
      div_cnt  <= '0;
    end else if (div_start) begin
      div_busy <= 1'b1;
      div_done <= 1'b0;
      div_cnt  <= '0;
    end else if (div_busy) begin
      div_cnt <= div_cnt + 7'd1;
      if (div_cnt == 7'(DW - 1)) begin
        div_busy <= 1'b0;
        div_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      div_quo <= div_dividend;
      div_rem <= '0;
      div_dsr <= div_divisor;
    end else if (div_busy) begin
      if (!div_diff[DW]) begin
        div_rem <= div_diff[DW-1:0];
        div_quo <= {div_quo[DW-2:0], 1'b1};
      end else begin
        div_rem <= div_shift[DW-1:0];
        div_quo <= {div_quo[DW-2:0], 1'b0};
      end
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      srg_pkg::ST_IDLE:
        if (accept && s_tuser == srg_pkg::FUNC_ADVANCE) begin
          state_next = (ph_eff == srg_pkg::PH_DONE) ? srg_pkg::ST_EMIT : srg_pkg::ST_PER;
        end
      srg_pkg::ST_PER:
        state_next = (per_zero || f_reg == '0) ? srg_pkg::ST_MUL : srg_pkg::ST_PER_WAIT;
      srg_pkg::ST_PER_WAIT: if (div_done) state_next = srg_pkg::ST_MUL;
      srg_pkg::ST_MUL:
        state_next = (c_reg == '0) ? srg_pkg::ST_TRIM : srg_pkg::ST_K_DIV;
      srg_pkg::ST_K_DIV:    state_next = srg_pkg::ST_K_WAIT;
      srg_pkg::ST_K_WAIT:   if (div_done) state_next = srg_pkg::ST_Q_DIV;
      srg_pkg::ST_Q_DIV:    state_next = srg_pkg::ST_Q_WAIT;
      srg_pkg::ST_Q_WAIT:   if (div_done) state_next = srg_pkg::ST_TRIM;
      srg_pkg::ST_TRIM:
        state_next = (last_stage && f_reg != '0) ? srg_pkg::ST_TRIM_WAIT : srg_pkg::ST_EMIT;
      srg_pkg::ST_TRIM_WAIT: if (div_done) state_next = srg_pkg::ST_EMIT;
      srg_pkg::ST_EMIT:     if (out_free) state_next = srg_pkg::ST_IDLE;
      default:              state_next = srg_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake and divider operands.
  always_comb begin
    s_tready     = 1'b0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    unique case (state)
      srg_pkg::ST_IDLE: s_tready = 1'b1;
      srg_pkg::ST_PER: begin
        div_start    = !per_zero && f_reg != '0;
        div_dividend = DW'(per_num - {13'b0, f_reg});
        div_divisor  = DW'({f_reg, 1'b0});
      end
      srg_pkg::ST_K_DIV: begin
        div_start    = 1'b1;
        div_dividend = dc_reg;
        div_divisor  = denom_reg;
      end
      srg_pkg::ST_Q_DIV: begin
        // Whole pulses times pulse length is the dividend less its remainder.
        div_start    = 1'b1;
        div_dividend = dc_reg - div_rem;
        div_divisor  = DW'(c_reg);
      end
      srg_pkg::ST_TRIM: begin
        div_start    = last_stage && f_reg != '0;
        div_dividend = DW'({end_trim, 16'b0});
        div_divisor  = DW'(f_reg);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= srg_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Datapath and profile state.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_freq  <= '0;
      stage_index   <= '0;
      deadline      <= '0;
      profile_phase <= srg_pkg::PH_DONE;
      m_tvalid      <= 1'b0;
    end else begin
      if (state == srg_pkg::ST_EMIT && out_free) m_tvalid <= 1'b1;
      else if (m_tready)                          m_tvalid <= 1'b0;
      unique case (state)
        srg_pkg::ST_IDLE:
          if (accept) begin
            if (s_tuser == srg_pkg::FUNC_START) begin
              current_freq  <= start_freq;
              stage_index   <= '0;
              deadline      <= s_tdata;
              profile_phase <= srg_pkg::PH_UP;
            end else begin
              profile_phase <= ph_eff;
              ph_cur        <= ph_eff;
              f_reg         <= current_freq;
              c_reg         <= c_pick;
              pre_reg       <= (ph_eff == srg_pkg::PH_DONE) ? '0 : pre_pick;
              per_reg       <= '0;
              span_reg      <= '0;
              trim_reg      <= '0;
              lst_reg       <= 1'b0;
            end
          end
        srg_pkg::ST_PER:
          if (per_zero)        per_reg <= '0;
          else if (f_reg == '0) per_reg <= PMAX;
        srg_pkg::ST_PER_WAIT:
          if (div_done) begin
            if (DW > PB && |div_quo[DW-1:PB]) per_reg <= PMAX;
            else                              per_reg <= div_quo[PB-1:0];
          end
        srg_pkg::ST_MUL: begin
          dc_reg    <= dc_prod;
          denom_reg <= DW'(denom_prod);
        end
        srg_pkg::ST_Q_WAIT:
          if (div_done) span_reg <= div_quo_rnd[31:0];
        srg_pkg::ST_TRIM:
          lst_reg <= last_stage;
        srg_pkg::ST_TRIM_WAIT:
          if (div_done) trim_reg <= div_quo_rnd[31:0];
        srg_pkg::ST_EMIT:
          if (out_free) begin
            m_tdata  <= OUT_TW'({deadline_new, per_reg, pre_reg});
            m_tuser  <= ph_cur;
            m_tlast  <= lst_reg;
            deadline <= deadline_new;
            unique case (ph_cur)
              srg_pkg::PH_UP: begin
                stage_index  <= idx_p1[15:0];
                current_freq <= freq_up;
                if (idx_p1 >= {1'b0, stage_count}) profile_phase <= srg_pkg::PH_CRUISE;
              end
              srg_pkg::PH_CRUISE: begin
                stage_index   <= '0;
                current_freq  <= freq_down;
                profile_phase <= srg_pkg::PH_DOWN;
              end
              srg_pkg::PH_DOWN: begin
                stage_index  <= idx_p1[15:0];
                current_freq <= freq_down;
                if (lst_reg) profile_phase <= srg_pkg::PH_DONE;
              end
              default: ;
            endcase
          end
        default: ;
      endcase
    end
  end

  a_div_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (state == srg_pkg::ST_PER_WAIT || state == srg_pkg::ST_K_WAIT ||
                  state == srg_pkg::ST_Q_WAIT || state == srg_pkg::ST_TRIM_WAIT))
    else $error("divider running outside a wait state");

  a_last_is_down: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser == srg_pkg::PH_DOWN)
    else $error("last stage flagged outside ramp-down");

  a_done_fast: assert property (@(posedge clk) disable iff (rst)
    accept && s_tuser == srg_pkg::FUNC_ADVANCE && ph_eff == srg_pkg::PH_DONE
    |=> state == srg_pkg::ST_EMIT)
    else $error("advance in done phase did not go straight to emit");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    state == srg_pkg::ST_EMIT && out_free |=> m_tvalid && state == srg_pkg::ST_IDLE)
    else $error("emitted stage not presented");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;

  localparam logic [35:0] FREQ_MAX = 36'hF_FFFF_FFFF;
  localparam int unsigned STAGE_DRAIN = 300;
  localparam int unsigned HOLD_CYCLES = 600;

  typedef struct {
    logic [2:0]      prescaler;
    logic [15:0]     period;
    logic [31:0]     deadline;
    srg_pkg::phase_t phase;
    logic            last;
  } stage_t;

  // Keeps its own copy of the ramp state and predicts each stage.
  class stage_scoreboard;
    logic [63:0] clock_hz, start_freq, freq_step, stage_count;
    logic [63:0] stage_us, cruise_us, end_trim;
    logic [63:0] freq;
    int unsigned index;
    logic [31:0] deadline;
    srg_pkg::phase_t phase;
    stage_t      pending[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned starts;
    int unsigned last_stages;

    function new();
      clock_hz = srg_pkg::CLOCK_HZ_RST;
      start_freq = srg_pkg::START_FREQ_RST;
      freq_step = srg_pkg::FREQ_STEP_RST;
      stage_count = srg_pkg::STAGE_COUNT_RST;
      stage_us = srg_pkg::STAGE_US_RST;
      cruise_us = srg_pkg::CRUISE_US_RST;
      end_trim = srg_pkg::END_TRIM_RST;
      freq = 0;
      index = 0;
      deadline = 0;
      phase = srg_pkg::PH_DONE;
      errors = 0;
      checked = 0;
      starts = 0;
      last_stages = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [35:0] data);
      case (idx)
        srg_pkg::REG_CLOCK_HZ:    clock_hz = data[31:0];
        srg_pkg::REG_START_FREQ:  start_freq = data;
        srg_pkg::REG_FREQ_STEP:   freq_step = data;
        srg_pkg::REG_STAGE_COUNT: stage_count = data[15:0];
        srg_pkg::REG_STAGE_US:    stage_us = data[19:0];
        srg_pkg::REG_CRUISE_US:   cruise_us = data[31:0];
        srg_pkg::REG_END_TRIM:    end_trim = data[31:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] pulse_span(logic [63:0] dur, logic [63:0] c, logic [63:0] per);
      logic [63:0] denom, k, q, r;
      if (c == 0) return 32'd0;
      denom = 64'd1000000 * (per + 1);
      k = (dur * c) / denom;
      q = (k * denom) / c;
      r = (k * denom) % c;
      if (2 * r >= c) q = q + 1;
      return q[31:0];
    endfunction

    function void note_command(logic func, logic [31:0] now);
      stage_t s;
      logic [63:0] c, per, num, q, r, f;
      int unsigned p;
      if (func == srg_pkg::FUNC_START) begin
        freq = start_freq;
        index = 0;
        deadline = now;
        phase = srg_pkg::PH_UP;
        starts++;
        return;
      end
      if (phase == srg_pkg::PH_UP && index >= stage_count) phase = srg_pkg::PH_CRUISE;
      if (phase == srg_pkg::PH_DOWN && index >= stage_count) phase = srg_pkg::PH_DONE;
      s.phase = phase;
      s.last = 1'b0;
      if (phase == srg_pkg::PH_DONE) begin
        s.prescaler = 0;
        s.period = 0;
        s.deadline = deadline;
        pending.push_back(s);
        return;
      end
      f = freq;
      p = 0;
      while (p < srg_pkg::MAX_PRESCALE_DEF && f < (clock_hz >> p)) p++;
      c = clock_hz >> p;
      num = c << 17;
      if (num <= f) per = 0;
      else if (f == 0) per = 64'hFFFF;
      else begin
        per = (num - f) / (2 * f);
        if (per > 64'hFFFF) per = 64'hFFFF;
      end
      case (phase)
        srg_pkg::PH_UP: begin
          index++;
          deadline += pulse_span(stage_us, c, per);
          freq = (FREQ_MAX - f < freq_step) ? FREQ_MAX : f + freq_step;
          if (index >= stage_count) phase = srg_pkg::PH_CRUISE;
        end
        srg_pkg::PH_CRUISE: begin
          index = 0;
          deadline += pulse_span(cruise_us, c, per);
          freq = (f < freq_step) ? 0 : f - freq_step;
          phase = srg_pkg::PH_DOWN;
        end
        default: begin
          index++;
          if (index == stage_count) begin
            s.last = 1'b1;
            if (f != 0) begin
              num = end_trim << 16;
              q = num / f;
              r = num % f;
              if (2 * r >= f) q = q + 1;
              deadline -= q[31:0];
            end
          end
          deadline += pulse_span(stage_us, c, per);
          freq = (f < freq_step) ? 0 : f - freq_step;
          if (s.last) phase = srg_pkg::PH_DONE;
        end
      endcase
      s.prescaler = p[2:0];
      s.period = per[15:0];
      s.deadline = deadline;
      pending.push_back(s);
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("MISMATCH at %0t: %s got %0h expected %0h", $time, what, got, want);
      errors++;
    endtask

    task check_stage(stage_t got);
      stage_t want;
      if (pending.size() == 0) begin
        report_mismatch("unexpected stage beat, deadline", got.deadline, 0);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (want.last) last_stages++;
      if (got.prescaler !== want.prescaler)
        report_mismatch("prescaler", got.prescaler, want.prescaler);
      if (got.period !== want.period) report_mismatch("period", got.period, want.period);
      if (got.deadline !== want.deadline)
        report_mismatch("deadline", got.deadline, want.deadline);
      if (got.phase !== want.phase) report_mismatch("phase", got.phase, want.phase);
      if (got.last !== want.last) report_mismatch("last", got.last, want.last);
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        s_tuser = srg_pkg::FUNC_START;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [35:0] cfg_data = '0;

  stage_scoreboard sb = new();
  int unsigned send_idle = 33;
  int unsigned recv_idle = 81;
  int unsigned sent = 0;
  int unsigned hold_reqs = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  stepper_ramp_stage_generator i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: random back-pressure, plus a long hold-off on request.
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    stage_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.prescaler = m_tdata[2:0];
      got.period = m_tdata[18:3];
      got.deadline = m_tdata[50:19];
      got.phase = srg_pkg::phase_t'(m_tuser);
      got.last = m_tlast;
      sb.check_stage(got);
    end
  end

  task write_reg(logic [2:0] idx, logic [35:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // The sender stays quiet until every expected stage has come back.
  task wait_results_in();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (STAGE_DRAIN) @(posedge clk);
  endtask

  task load_settings(logic [31:0] clk_hz, logic [35:0] f0, logic [35:0] step,
                     logic [15:0] count, logic [19:0] st_us, logic [31:0] cr_us,
                     logic [31:0] trim);
    wait_results_in();
    write_reg(srg_pkg::REG_CLOCK_HZ, {4'($urandom_range(15)), clk_hz});
    write_reg(srg_pkg::REG_START_FREQ, f0);
    write_reg(srg_pkg::REG_FREQ_STEP, step);
    write_reg(srg_pkg::REG_STAGE_COUNT, {4'h0, 16'($urandom_range(65535)), count});
    write_reg(srg_pkg::REG_STAGE_US, {16'($urandom_range(65535)), st_us});
    write_reg(srg_pkg::REG_CRUISE_US, {4'hF, cr_us});
    write_reg(srg_pkg::REG_END_TRIM, {4'($urandom_range(15)), trim});
    // Index seven is not a register and must change nothing.
    write_reg(3'd7, {4'($urandom_range(15)), $urandom});
  endtask

  task send(logic func, logic [31:0] now);
    if (sent < 233) begin
      send_idle = 33;
      recv_idle = 81;
    end else if (sent < 466) begin
      send_idle = 81;
      recv_idle = 33;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= func;
    s_tdata <= now;
    do @(posedge clk); while (!s_tready);
    sb.note_command(func, now);
    sent++;
  endtask

  task run_profile(int unsigned advances);
    send(srg_pkg::FUNC_START, $urandom);
    repeat (advances) send(srg_pkg::FUNC_ADVANCE, $urandom);
  endtask

  task random_phase(int unsigned items);
    int unsigned n, cnt, len;
    n = 0;
    while (n < items) begin
      if ($urandom_range(99) < 85) begin
        cnt = 32'(sb.stage_count);
        len = 2 * cnt + 1 + $urandom_range(2);
        if (len > 40 || cnt == 0) len = $urandom_range(1, 40);
        run_profile(len);
        n += len + 1;
      end else begin
        send(1'($urandom_range(1)), $urandom);
        n++;
      end
    end
  endtask

  initial begin
    logic [31:0] ck;
    logic [35:0] f0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: advancing a finished profile, then the default trapezoid.
    send(srg_pkg::FUNC_ADVANCE, 32'hFFFF_FFFF);
    send(srg_pkg::FUNC_START, 32'h0);
    repeat (4) send(srg_pkg::FUNC_ADVANCE, 32'h0);
    send(srg_pkg::FUNC_START, 32'hFFFF_FFFF);
    repeat (4) send(srg_pkg::FUNC_ADVANCE, 32'hFFFF_FFFF);

    // Slowest clock, smallest frequency, largest cruise time and trim.
    load_settings(32'd1, 36'd1, 36'd0, 16'd1, 20'd1000000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_profile(4);
    // Largest clock and frequency; the step drops the frequency to zero.
    load_settings(32'hFFFF_FFFF, FREQ_MAX, FREQ_MAX, 16'd2, 20'd1, 32'd0, 32'hFFFF_FFFF);
    run_profile(6);
    // Zero stage count skips both ramps.
    load_settings(32'd50000000, 36'd196608000, 36'd6553600, 16'd0, 20'd200, 32'd1000, 32'd0);
    run_profile(3);

    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(3))
        0: ck = $urandom;
        1: ck = $urandom_range(1, 255);
        default: ck = $urandom_range(1000000, 100000000);
      endcase
      if ($urandom_range(1)) f0 = {4'($urandom_range(15)), $urandom};
      else f0 = 36'($urandom_range(1, 200000)) << 16;
      load_settings(ck, f0,
                    $urandom_range(1) ? {4'($urandom_range(15)), $urandom}
                                      : 36'($urandom_range(0, 5000)) << 16,
                    ph == 5 ? 16'hFFFF : 16'($urandom_range(1, 6)),
                    $urandom_range(1) ? 20'($urandom_range(1, 1000000))
                                      : 20'($urandom_range(1, 2000)),
                    $urandom, $urandom);
      if (ph == 3) begin
        // Long receiver hold-off while advances keep coming.
        hold_reqs++;
        run_profile(8);
        wait_results_in();
      end
      random_phase(55);
    end

    wait_results_in();
    $display("Ran %0d commands (%0d starts), checked %0d stages, %0d final ramp-down stages.",
             sent, sb.starts, sb.checked, sb.last_stages);
    $display("Covered default, extreme and random register settings under mixed back-pressure.");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #30000000;
    $display("Timeout with %0d stages outstanding.", sb.pending.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== stepper_ramp_stage_generator.f =====
hdl/srg_pkg.sv
hdl/stepper_ramp_stage_generator.sv
tb/tb_top.sv
